>>> src/assert_macros.svh
// Assertion macros shared by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define CLBP_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define CLBP_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/clbp_pkg.sv
// Shared widths, types and ALU codes for the CPU load blink pacer.
package clbp_pkg;

   localparam int unsigned DATA_W     = 64;
   localparam int unsigned CPU_W      = 13;
   localparam int unsigned LEVEL_W    = 8;
   localparam int unsigned PCT_W      = 7;
   localparam int unsigned WAIT_W     = 7;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      logic [CPU_W-1:0]   cpu_count;
      logic               invert;
      logic [LEVEL_W-1:0] brightness;
   } cfg_type;

endpackage

>>> src/cpu_load_blink_pacer_unit.sv
// Top level: CSR registers and the pacing core.
// Activity LED pacer. Each request carries the cumulative busy time and boot time;
// the response gives whether the LED is written this tick, the level, the wait until
// the next tick (1..100 ms, 0 once a panic has been seen) and the load percentage.
// One request is in work at a time; req_ready is high only while idle. A normal
// request runs a 13-step shift-add multiply of boot time by CPU count, two
// subtractions and up to three 10-step restoring divisions, all through one
// shared 64-bit adder; a panic request skips them. The response sits in an
// output register, so a new request can be taken while it waits; a request that
// finishes while the previous response is still held stays in its last state
// until that one is taken.
// CSRs (APB, pready tied high): 0x0 cpu_count, 0x4 invert, 0x8 brightness; write
// only while no request is in work.
module cpu_load_blink_pacer_unit import clbp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [DATA_W-1:0]     req_busy_total,
   input  logic [DATA_W-1:0]     req_boot_ns,
   input  logic                  req_panic,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_led_write,
   output logic [LEVEL_W-1:0]    rsp_led_level,
   output logic [WAIT_W-1:0]     rsp_wait_ms,
   output logic [PCT_W-1:0]      rsp_load_pct,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam logic [1:0] REG_CPU_COUNT  = 2'd0;
   localparam logic [1:0] REG_INVERT     = 2'd1;
   localparam logic [1:0] REG_BRIGHTNESS = 2'd2;

   logic [CPU_W-1:0]   cpu_count_ff, cpu_count_in;
   logic               invert_ff, invert_in;
   logic [LEVEL_W-1:0] brightness_ff, brightness_in;
   logic               csr_wr;
   logic [1:0]         csr_idx;
   cfg_type            cfg;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   always_comb begin
      cpu_count_in  = cpu_count_ff;
      invert_in     = invert_ff;
      brightness_in = brightness_ff;
      csr_prdata    = '0;
      unique case (csr_idx)
         REG_CPU_COUNT: begin
            csr_prdata = CSR_DATA_W'(cpu_count_ff);
            if (csr_wr) begin
               cpu_count_in = csr_pwdata[CPU_W-1:0];
            end
         end
         REG_INVERT: begin
            csr_prdata = CSR_DATA_W'(invert_ff);
            if (csr_wr) begin
               invert_in = csr_pwdata[0];
            end
         end
         REG_BRIGHTNESS: begin
            csr_prdata = CSR_DATA_W'(brightness_ff);
            if (csr_wr) begin
               brightness_in = csr_pwdata[LEVEL_W-1:0];
            end
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_count_ff  <= CPU_W'(1);
         invert_ff     <= 1'b0;
         brightness_ff <= '1;
      end else begin
         cpu_count_ff  <= cpu_count_in;
         invert_ff     <= invert_in;
         brightness_ff <= brightness_in;
      end
   end

   assign cfg.cpu_count  = cpu_count_ff;
   assign cfg.invert     = invert_ff;
   assign cfg.brightness = brightness_ff;

   clbp_core u_core (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_busy_total (req_busy_total),
      .req_boot_ns    (req_boot_ns),
      .req_panic      (req_panic),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_led_write  (rsp_led_write),
      .rsp_led_level  (rsp_led_level),
      .rsp_wait_ms    (rsp_wait_ms),
      .rsp_load_pct   (rsp_load_pct)
   );

endmodule

>>> src/clbp_alu.sv
// Shared 64-bit add/subtract unit with carry/borrow out.
module clbp_alu import clbp_pkg::*; (
   input  alu_op_type        op,
   input  logic [DATA_W-1:0] a,
   input  logic [DATA_W-1:0] b,
   output logic [DATA_W-1:0] res,
   output logic              carry
);

   logic [DATA_W:0] full;

   always_comb begin
      unique case (op)
         ALU_ADD: full = {1'b0, a} + {1'b0, b};
         ALU_SUB: full = {1'b0, a} - {1'b0, b};
         default: full = '0;
      endcase
   end

   assign res   = full[DATA_W-1:0];
   assign carry = full[DATA_W];

endmodule

>>> src/clbp_core.sv
// Sequencer and datapath: multiply, differences, load, phase and wait per request.
module clbp_core import clbp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [DATA_W-1:0]  req_busy_total,
   input  logic [DATA_W-1:0]  req_boot_ns,
   input  logic               req_panic,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_led_write,
   output logic [LEVEL_W-1:0] rsp_led_level,
   output logic [WAIT_W-1:0]  rsp_wait_ms,
   output logic [PCT_W-1:0]   rsp_load_pct
);

   localparam int unsigned TR_W      = 10;
   localparam int unsigned TGT_W     = 6;
   localparam int unsigned DIFF_LSB  = 16;
   localparam int unsigned DIFF_W    = 32;
   localparam int unsigned QUO_W     = 10;
   localparam int unsigned NUM_W     = 38;
   localparam int unsigned DVS_W     = DIFF_W - 1 + QUO_W - 1;
   localparam int unsigned CNT_W     = 4;
   localparam int unsigned MUL_STEPS = CPU_W;

   localparam int unsigned LOAD_FULL    = 100;
   localparam int unsigned WAIT_CAP     = 100;
   localparam int unsigned TARGET_ONE   = 50;
   localparam int unsigned LO_BASE      = 990;
   localparam int unsigned LO_SPAN      = 900;
   localparam int unsigned HI_SPAN      = 80;
   localparam int unsigned HI_OFF_BASE  = 90;
   localparam int unsigned ON_TIME      = 10;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DBOOT,
      ST_DBUSY,
      ST_USAGE,
      ST_DIV,
      ST_TGT,
      ST_DELAY,
      ST_FIN,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      DIV_USAGE,
      DIV_TARGET,
      DIV_LO,
      DIV_HI
   } div_sel_type;

   state_type                 state_ff, state_in;
   div_sel_type               div_sel_ff, div_sel_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [DATA_W-1:0]         acc_ff, acc_in;
   logic [DATA_W-1:0]         mcand_ff, mcand_in;
   logic [CPU_W-1:0]          mplier_ff, mplier_in;
   logic [DATA_W-1:0]         busy_ff, busy_in;
   logic [DATA_W-1:0]         prev_boot_ff, prev_boot_in;
   logic [DATA_W-1:0]         prev_busy_ff, prev_busy_in;
   logic signed [DIFF_W-1:0]  d_boot_ff, d_boot_in;
   logic signed [DIFF_W-1:0]  d_busy_ff, d_busy_in;
   logic [NUM_W-1:0]          rem_ff, rem_in;
   logic [DVS_W-1:0]          dvs_ff, dvs_in;
   logic [QUO_W-1:0]          quo_ff, quo_in;
   logic [PCT_W-1:0]          usage_ff, usage_in;
   logic [TGT_W-1:0]          target_ff, target_in;
   logic [TR_W-1:0]           delay_ff, delay_in;
   logic [TR_W-1:0]           tr_ff, tr_in;
   logic                      phase_ff, phase_in;
   logic                      panic_ff, panic_in;
   logic                      res_write_ff, res_write_in;
   logic [LEVEL_W-1:0]        res_level_ff, res_level_in;
   logic [WAIT_W-1:0]         res_wait_ff, res_wait_in;
   logic [PCT_W-1:0]          res_load_ff, res_load_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_write_ff, rsp_write_in;
   logic [LEVEL_W-1:0]        rsp_level_ff, rsp_level_in;
   logic [WAIT_W-1:0]         rsp_wait_ff, rsp_wait_in;
   logic [PCT_W-1:0]          rsp_load_ff, rsp_load_in;

   alu_op_type                alu_op;
   logic [DATA_W-1:0]         alu_a;
   logic [DATA_W-1:0]         alu_b;
   logic [DATA_W-1:0]         alu_res;
   logic                      alu_carry;
   logic [CPU_W-1:0]          eff_cpus;
   logic [QUO_W-1:0]          quo_step;
   logic [TR_W-1:0]           fin_tr;
   logic                      rsp_free;

   clbp_alu u_alu (
      .op    (alu_op),
      .a     (alu_a),
      .b     (alu_b),
      .res   (alu_res),
      .carry (alu_carry)
   );

   assign eff_cpus  = (cfg.cpu_count == '0) ? CPU_W'(1) : cfg.cpu_count;
   assign quo_step  = {quo_ff[QUO_W-2:0], ~alu_carry};
   assign fin_tr    = ((tr_ff == '0) || (delay_ff <= tr_ff)) ? delay_ff : tr_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      div_sel_in   = div_sel_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      busy_in      = busy_ff;
      prev_boot_in = prev_boot_ff;
      prev_busy_in = prev_busy_ff;
      d_boot_in    = d_boot_ff;
      d_busy_in    = d_busy_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      quo_in       = quo_ff;
      usage_in     = usage_ff;
      target_in    = target_ff;
      delay_in     = delay_ff;
      tr_in        = tr_ff;
      phase_in     = phase_ff;
      panic_in     = panic_ff;
      res_write_in = res_write_ff;
      res_level_in = res_level_ff;
      res_wait_in  = res_wait_ff;
      res_load_in  = res_load_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_write_in = rsp_write_ff;
      rsp_level_in = rsp_level_ff;
      rsp_wait_in  = rsp_wait_ff;
      rsp_load_in  = rsp_load_ff;
      alu_op       = ALU_SUB;
      alu_a        = '0;
      alu_b        = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_write_in = 1'b0;
               res_level_in = '0;
               if (req_panic || panic_ff) begin
                  panic_in     = 1'b1;
                  res_write_in = 1'b1;
                  res_level_in = cfg.brightness;
                  res_wait_in  = '0;
                  res_load_in  = '0;
                  state_in     = ST_DONE;
               end else begin
                  acc_in    = '0;
                  mcand_in  = req_boot_ns;
                  mplier_in = eff_cpus;
                  busy_in   = req_busy_total;
                  cnt_in    = CNT_W'(MUL_STEPS - 1);
                  state_in  = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            alu_op    = ALU_ADD;
            alu_a     = acc_ff;
            alu_b     = mplier_ff[0] ? mcand_ff : '0;
            acc_in    = alu_res;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_DBOOT;
            end
         end
         ST_DBOOT: begin
            alu_a        = acc_ff;
            alu_b        = prev_boot_ff;
            d_boot_in    = alu_res[DIFF_LSB+DIFF_W-1:DIFF_LSB];
            prev_boot_in = acc_ff;
            state_in     = ST_DBUSY;
         end
         ST_DBUSY: begin
            alu_a        = busy_ff;
            alu_b        = prev_busy_ff;
            d_busy_in    = alu_res[DIFF_LSB+DIFF_W-1:DIFF_LSB];
            prev_busy_in = busy_ff;
            state_in     = ST_USAGE;
         end
         ST_USAGE: begin
            priority if ((d_boot_ff <= 32'sd0) || (d_busy_ff < 32'sd0)) begin
               usage_in = '0;
               state_in = ST_TGT;
            end else if (d_busy_ff >= d_boot_ff) begin
               usage_in = PCT_W'(LOAD_FULL);
               state_in = ST_TGT;
            end else begin
               rem_in     = NUM_W'(LOAD_FULL) * NUM_W'(d_busy_ff[DIFF_W-2:0]);
               dvs_in     = DVS_W'(d_boot_ff[DIFF_W-2:0]) << (QUO_W - 1);
               quo_in     = '0;
               cnt_in     = CNT_W'(QUO_W - 1);
               div_sel_in = DIV_USAGE;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            alu_a = DATA_W'(rem_ff);
            alu_b = DATA_W'(dvs_ff);
            if (!alu_carry) begin
               rem_in = alu_res[NUM_W-1:0];
            end
            quo_in = quo_step;
            dvs_in = dvs_ff >> 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               unique case (div_sel_ff)
                  DIV_USAGE: begin
                     usage_in = quo_step[PCT_W-1:0];
                     state_in = ST_TGT;
                  end
                  DIV_TARGET: begin
                     target_in = quo_step[TGT_W-1:0];
                     state_in  = ST_DELAY;
                  end
                  DIV_LO: begin
                     delay_in = TR_W'(LO_BASE) - TR_W'(quo_step);
                     state_in = ST_FIN;
                  end
                  DIV_HI: begin
                     delay_in = phase_ff ? TR_W'(ON_TIME) + TR_W'(quo_step)
                                         : TR_W'(HI_OFF_BASE) - TR_W'(quo_step);
                     state_in = ST_FIN;
                  end
                  default: state_in = ST_FIN;
               endcase
            end
         end
         ST_TGT: begin
            if (tr_ff <= TR_W'(WAIT_CAP)) begin
               tr_in        = '0;
               phase_in     = ~phase_ff;
               res_write_in = 1'b1;
               res_level_in = (~phase_ff ^ cfg.invert) ? cfg.brightness : '0;
            end else begin
               tr_in = tr_ff - TR_W'(WAIT_CAP);
            end
            if (eff_cpus > CPU_W'(1)) begin
               rem_in     = NUM_W'(LOAD_FULL);
               dvs_in     = DVS_W'(eff_cpus) << (QUO_W - 1);
               quo_in     = '0;
               cnt_in     = CNT_W'(QUO_W - 1);
               div_sel_in = DIV_TARGET;
               state_in   = ST_DIV;
            end else begin
               target_in = TGT_W'(TARGET_ONE);
               state_in  = ST_DELAY;
            end
         end
         ST_DELAY: begin
            quo_in = '0;
            cnt_in = CNT_W'(QUO_W - 1);
            if (usage_ff < PCT_W'(target_ff)) begin
               if (phase_ff) begin
                  delay_in = TR_W'(ON_TIME);
                  state_in = ST_FIN;
               end else begin
                  rem_in     = NUM_W'(LO_SPAN) * NUM_W'(usage_ff);
                  dvs_in     = DVS_W'(target_ff) << (QUO_W - 1);
                  div_sel_in = DIV_LO;
                  state_in   = ST_DIV;
               end
            end else begin
               rem_in     = NUM_W'(HI_SPAN) * NUM_W'(usage_ff - PCT_W'(target_ff));
               dvs_in     = DVS_W'(PCT_W'(LOAD_FULL) - PCT_W'(target_ff)) << (QUO_W - 1);
               div_sel_in = DIV_HI;
               state_in   = ST_DIV;
            end
         end
         ST_FIN: begin
            tr_in       = fin_tr;
            res_wait_in = (fin_tr > TR_W'(WAIT_CAP)) ? WAIT_W'(WAIT_CAP)
                                                     : fin_tr[WAIT_W-1:0];
            res_load_in = usage_ff;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_write_in = res_write_ff;
               rsp_level_in = res_level_ff;
               rsp_wait_in  = res_wait_ff;
               rsp_load_in  = res_load_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tr_ff        <= '0;
         phase_ff     <= 1'b0;
         panic_ff     <= 1'b0;
         prev_boot_ff <= '0;
         prev_busy_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tr_ff        <= tr_in;
         phase_ff     <= phase_in;
         panic_ff     <= panic_in;
         prev_boot_ff <= prev_boot_in;
         prev_busy_ff <= prev_busy_in;
         rsp_write_ff <= rsp_write_in;
         rsp_level_ff <= rsp_level_in;
         rsp_wait_ff  <= rsp_wait_in;
         rsp_load_ff  <= rsp_load_in;
      end
   end

   always_ff @(posedge clock) begin
      div_sel_ff   <= div_sel_in;
      cnt_ff       <= cnt_in;
      acc_ff       <= acc_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      busy_ff      <= busy_in;
      d_boot_ff    <= d_boot_in;
      d_busy_ff    <= d_busy_in;
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      quo_ff       <= quo_in;
      usage_ff     <= usage_in;
      target_ff    <= target_in;
      delay_ff     <= delay_in;
      res_write_ff <= res_write_in;
      res_level_ff <= res_level_in;
      res_wait_ff  <= res_wait_in;
      res_load_ff  <= res_load_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_led_write = rsp_write_ff;
   assign rsp_led_level = rsp_level_ff;
   assign rsp_wait_ms   = rsp_wait_ff;
   assign rsp_load_pct  = rsp_load_ff;

endmodule

>>> src/clbp_checker.sv
// Port-level assertions for the pacer, bound to the top level.
`include "assert_macros.svh"

module clbp_checker import clbp_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_led_write,
   input logic [LEVEL_W-1:0] rsp_led_level,
   input logic [WAIT_W-1:0]  rsp_wait_ms,
   input logic [PCT_W-1:0]   rsp_load_pct
);

   `CLBP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_led_write) && $stable(rsp_led_level) && $stable(rsp_wait_ms) && $stable(rsp_load_pct))
   `CLBP_ASSERT_IMP(a_rsp_range, rsp_valid, (rsp_wait_ms <= 7'd100) && (rsp_load_pct <= 7'd100))
   `CLBP_ASSERT_IMP(a_no_toggle, rsp_valid && !rsp_led_write, (rsp_led_level == '0) && (rsp_wait_ms != '0))
   `CLBP_ASSERT_IMP(a_stopped, rsp_valid && (rsp_wait_ms == '0), rsp_led_write && (rsp_load_pct == '0))
   `CLBP_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)

endmodule

bind cpu_load_blink_pacer_unit clbp_checker u_clbp_checker (.*);

>>> tb/sv/tb_top.sv
// Self-checking testbench for cpu_load_blink_pacer_unit: directed table, random ticks, panic.
`timescale 1ns / 1ps

module tb_top import clbp_pkg::*; ;

   typedef struct packed {
      logic               led_write;
      logic [LEVEL_W-1:0] led_level;
      logic [WAIT_W-1:0]  wait_ms;
      logic [PCT_W-1:0]   load_pct;
   } tick_result_type;

   typedef struct packed {
      logic [DATA_W-1:0] busy;
      logic [DATA_W-1:0] boot;
      logic              panic;
      logic              typed;
      tick_result_type   want;
   } tick_row_type;

   localparam logic [CSR_ADDR_W-1:0] REG_CPU_COUNT  = 4'h0;
   localparam logic [CSR_ADDR_W-1:0] REG_INVERT     = 4'h4;
   localparam logic [CSR_ADDR_W-1:0] REG_BRIGHTNESS = 4'h8;

   localparam int SETTLE_CYCLES = 60;
   localparam int NUM_PHASES    = 14;
   localparam int PHASE_TICKS   = 100;
   localparam int NUM_ROWS      = 23;

   localparam int CPU_PLAN [NUM_PHASES] =
      '{1, 0, 2, 3, 4, 7, 33, 50, 99, 100, 101, 1000, 4096, 8191};

   // reset config: one CPU, no invert, full brightness
   localparam tick_row_type DIRECTED [NUM_ROWS] = '{
      '{64'd0,              64'd0,              1'b0, 1'b1, '{1'b1, 8'd255, 7'd10,  7'd0}},
      '{64'd1000 << 16,     64'd1000 << 16,     1'b0, 1'b1, '{1'b1, 8'd0,   7'd10,  7'd100}},
      '{64'd0,              64'd2000 << 16,     1'b0, 1'b1, '{1'b1, 8'd255, 7'd10,  7'd0}},
      '{64'd500 << 16,      64'd3000 << 16,     1'b0, 1'b1, '{1'b1, 8'd0,   7'd90,  7'd50}},
      '{64'd750 << 16,      64'd4000 << 16,     1'b0, 1'b1, '{1'b1, 8'd255, 7'd10,  7'd25}},
      '{64'd750 << 16,      64'd5000 << 16,     1'b0, 1'b1, '{1'b1, 8'd0,   7'd100, 7'd0}},
      '{64'd751 << 16,      64'd6000 << 16,     1'b0, 1'b1, '{1'b0, 8'd0,   7'd100, 7'd0}},
      '{64'd751 << 16,      64'd6000 << 16,     1'b0, 1'b1, '{1'b0, 8'd0,   7'd100, 7'd0}},
      '{64'd751 << 16,      64'd0,              1'b0, 1'b1, '{1'b0, 8'd0,   7'd100, 7'd0}},
      '{64'd1651 << 16,     64'd1000 << 16,     1'b0, 1'b0, '0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
      '{64'd0,              64'd0,              1'b0, 1'b0, '0},
      '{64'h8000_0000_0000_0000, 64'h0000_7FFF_FFFF_0000, 1'b0, 1'b0, '0},
      '{64'h8000_7FFF_FFFF_0000, 64'h0000_FFFF_FFFE_0000, 1'b0, 1'b0, '0},
      '{64'h8000_FFFF_FFFF_0000, 64'h0001_0000_FFFE_0000, 1'b0, 1'b0, '0},
      '{64'h8001_0000_0000_0000, 64'h0001_8000_FFFE_0000, 1'b0, 1'b0, '0},
      '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, '0},
      '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, 1'b0, '0},
      '{64'hAAAA_AAAA_AAB4_AAAA, 64'h5555_5555_5941_5555, 1'b0, 1'b0, '0},
      '{64'hFFFF_FFFF_FFFF_0000, 64'h5555_5555_5D29_5555, 1'b0, 1'b0, '0},
      '{64'h0000_0000_0031_0000, 64'h5555_5555_6111_5555, 1'b0, 1'b0, '0},
      '{64'h0000_0000_0400_0000, 64'h5555_5555_64F9_5555, 1'b0, 1'b0, '0},
      '{64'h0000_0000_0401_0000, 64'h5555_5555_68E1_5555, 1'b0, 1'b0, '0}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [DATA_W-1:0]     req_busy_total;
   logic [DATA_W-1:0]     req_boot_ns;
   logic                  req_panic;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_led_write;
   logic [LEVEL_W-1:0]    rsp_led_level;
   logic [WAIT_W-1:0]     rsp_wait_ms;
   logic [PCT_W-1:0]      rsp_load_pct;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cfg_type         cfg;
   bit [63:0]       last_boot_scaled;
   bit [63:0]       last_busy;
   int              ms_left;
   bit              led_phase_on;
   bit              panic_seen;
   tick_result_type pending_ticks [$];
   int              err_count;
   bit              quiet_phase;
   bit [63:0]       trk_busy;
   bit [63:0]       trk_boot;

   cpu_load_blink_pacer_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_busy_total (req_busy_total),
      .req_boot_ns    (req_boot_ns),
      .req_panic      (req_panic),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_led_write  (rsp_led_write),
      .rsp_led_level  (rsp_led_level),
      .rsp_wait_ms    (rsp_wait_ms),
      .rsp_load_pct   (rsp_load_pct),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic void flag_error(string msg);
      if (err_count < 10) begin
         $display("%s", msg);
      end
      err_count++;
   endfunction

   // (now - was) >> 16, low 32 bits taken as signed
   function automatic longint scaled_delta(bit [63:0] now_v, bit [63:0] was_v);
      bit [63:0] d;
      int        low;
      d = now_v - was_v;
      low = int'(d[47:16]);
      return longint'(low);
   endfunction

   function automatic tick_result_type pace_tick(bit [63:0] busy, bit [63:0] boot, bit panic);
      tick_result_type r;
      bit [63:0]       cpus;
      bit [63:0]       boot_scaled;
      longint          d_boot;
      longint          d_busy;
      longint          load;
      longint          goal;
      longint          hold;
      r = '0;
      if (panic) begin
         panic_seen = 1'b1;
      end
      if (panic_seen) begin
         r.led_write = 1'b1;
         r.led_level = cfg.brightness;
         return r;
      end
      cpus = (cfg.cpu_count == '0) ? 64'd1 : 64'(cfg.cpu_count);
      boot_scaled = boot * cpus;
      d_boot = scaled_delta(boot_scaled, last_boot_scaled);
      d_busy = scaled_delta(busy, last_busy);
      last_boot_scaled = boot_scaled;
      last_busy = busy;
      if (d_boot <= 0 || d_busy < 0) begin
         load = 0;
      end else if (d_busy >= d_boot) begin
         load = 100;
      end else begin
         load = (100 * d_busy) / d_boot;
      end
      ms_left -= 100;
      if (ms_left <= 0) begin
         ms_left = 0;
         led_phase_on = ~led_phase_on;
         r.led_write = 1'b1;
         r.led_level = (led_phase_on ^ cfg.invert) ? cfg.brightness : '0;
      end
      goal = (cpus > 1) ? longint'(64'd100 / cpus) : 64'sd50;
      if (load < goal) begin
         hold = led_phase_on ? 64'sd10 : 990 - (900 * load) / goal;
      end else if (led_phase_on) begin
         hold = 10 + (80 * (load - goal)) / (100 - goal);
      end else begin
         hold = 90 - (80 * (load - goal)) / (100 - goal);
      end
      if (ms_left == 0 || hold <= ms_left) begin
         ms_left = int'(hold);
      end
      r.wait_ms = (ms_left < 100) ? WAIT_W'(ms_left) : WAIT_W'(100);
      r.load_pct = PCT_W'(load);
      return r;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] reg_image(logic [CSR_ADDR_W-1:0] addr);
      case (addr)
         REG_CPU_COUNT:  return CSR_DATA_W'(cfg.cpu_count);
         REG_INVERT:     return CSR_DATA_W'(cfg.invert);
         REG_BRIGHTNESS: return CSR_DATA_W'(cfg.brightness);
         default:        return '0;
      endcase
   endfunction

   // starts and ends at a falling edge
   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      logic [CSR_DATA_W-1:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (write) begin
         case (addr)
            REG_CPU_COUNT:  cfg.cpu_count = data[CPU_W-1:0];
            REG_INVERT:     cfg.invert = data[0];
            REG_BRIGHTNESS: cfg.brightness = data[LEVEL_W-1:0];
            default:        ;
         endcase
      end else begin
         want = reg_image(addr);
         if (csr_prdata !== want) begin
            flag_error($sformatf("csr read 0x%0h: expected 0x%0h, got 0x%0h",
                                 addr, want, csr_prdata));
         end
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_set(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_access(1'b1, addr, data);
      csr_access(1'b0, addr, '0);
   endtask

   // idle the request side and let the block finish before a register write
   task automatic drain_requests();
      req_valid <= 1'b0;
      while (pending_ticks.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_tick(input bit [63:0] busy, input bit [63:0] boot, input bit panic,
                            input bit typed, input tick_result_type want);
      int              gap;
      tick_result_type predicted;
      gap = quiet_phase ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_busy_total <= busy;
      req_boot_ns    <= boot;
      req_panic      <= panic;
      do @(posedge clock); while (!req_ready);
      predicted = pace_tick(busy, boot, panic);
      pending_ticks.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   // mostly steady load with random content, some garbage and backward steps
   task automatic draw_tick(output bit [63:0] busy, output bit [63:0] boot);
      int        pick;
      bit [63:0] step;
      bit [63:0] cpus;
      pick = $urandom_range(0, 99);
      cpus = (cfg.cpu_count == '0) ? 64'd1 : 64'(cfg.cpu_count);
      if (pick < 80) begin
         step = $urandom_range(1, 100_000_000);
         trk_boot += step;
         trk_busy += ((step * cpus) / 100) * $urandom_range(0, 115);
      end else if (pick < 88) begin
         trk_busy = {$urandom, $urandom};
         trk_boot = {$urandom, $urandom};
      end else if (pick < 93) begin
         trk_busy -= {32'b0, $urandom};
         trk_boot += $urandom_range(0, 50_000_000);
      end else begin
         trk_busy += $urandom_range(0, 65535);
         trk_boot += $urandom_range(0, 65535);
      end
      busy = trk_busy;
      boot = trk_boot;
   endtask

   always @(posedge clock) begin
      tick_result_type got;
      tick_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_led_write, rsp_led_level, rsp_wait_ms, rsp_load_pct};
         if (pending_ticks.size() == 0) begin
            flag_error($sformatf("unexpected response write=%0d level=%0d wait=%0d load=%0d",
                                 got.led_write, got.led_level, got.wait_ms, got.load_pct));
         end else begin
            want = pending_ticks.pop_front();
            if (got !== want) begin
               flag_error($sformatf({"mismatch: expected write=%0d level=%0d wait=%0d load=%0d,",
                                     " got write=%0d level=%0d wait=%0d load=%0d"},
                                    want.led_write, want.led_level, want.wait_ms, want.load_pct,
                                    got.led_write, got.led_level, got.wait_ms, got.load_pct));
            end
         end
      end
   end

   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = quiet_phase ? 0 : $urandom_range(0, 10);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      bit [63:0] busy;
      bit [63:0] boot;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_busy_total = '0;
      req_boot_ns    = '0;
      req_panic      = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      cfg            = '{cpu_count: 13'd1, invert: 1'b0, brightness: 8'd255};
      last_boot_scaled = '0;
      last_busy      = '0;
      ms_left        = 0;
      led_phase_on   = 1'b0;
      panic_seen     = 1'b0;
      err_count      = 0;
      quiet_phase    = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      csr_access(1'b0, REG_CPU_COUNT, '0);
      csr_access(1'b0, REG_INVERT, '0);
      csr_access(1'b0, REG_BRIGHTNESS, '0);

      for (int i = 0; i < NUM_ROWS; i++) begin
         send_tick(DIRECTED[i].busy, DIRECTED[i].boot, DIRECTED[i].panic,
                   DIRECTED[i].typed, DIRECTED[i].want);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_requests();
         quiet_phase = (p % 4 == 2);
         csr_set(REG_CPU_COUNT, CSR_DATA_W'(CPU_PLAN[p]));
         csr_set(REG_INVERT, CSR_DATA_W'(p % 2));
         csr_set(REG_BRIGHTNESS, (p == 0) ? 32'd0 : (p == 1) ? 32'd255 : $urandom_range(0, 255));
         trk_busy = {$urandom, $urandom};
         trk_boot = {$urandom, $urandom};
         for (int i = 0; i < PHASE_TICKS; i++) begin
            draw_tick(busy, boot);
            send_tick(busy, boot, 1'b0, 1'b0, '0);
         end
      end

      // panic latches for the rest of the run
      drain_requests();
      quiet_phase = 1'b0;
      csr_set(REG_BRIGHTNESS, 32'h5A);
      for (int i = 0; i < 14; i++) begin
         draw_tick(busy, boot);
         send_tick(busy, boot, (i == 0) ? 1'b1 : 1'($urandom_range(0, 1)), 1'b0, '0);
      end
      drain_requests();
      csr_set(REG_BRIGHTNESS, 32'd0);
      csr_set(REG_INVERT, 32'd1);
      csr_set(REG_CPU_COUNT, 32'd3);
      for (int i = 0; i < 6; i++) begin
         draw_tick(busy, boot);
         send_tick(busy, boot, 1'b0, 1'b0, '0);
      end
      drain_requests();

      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> cpu_load_blink_pacer_unit.f
+incdir+src
src/clbp_pkg.sv
src/clbp_alu.sv
src/clbp_core.sv
src/cpu_load_blink_pacer_unit.sv
src/clbp_checker.sv
tb/sv/tb_top.sv
